// ===== rtl/core/aus_pkg.sv =====
// ----------------------------------------------------------------------------
// aus_pkg
// shared types and codes of the absolute url splitter
// ----------------------------------------------------------------------------
package aus_pkg;

    // part codes carried on the output word
    localparam logic [2:0] PART_SCHEME = 3'd0;
    localparam logic [2:0] PART_HOST   = 3'd1;
    localparam logic [2:0] PART_PORT   = 3'd2;
    localparam logic [2:0] PART_PATH   = 3'd3;
    localparam logic [2:0] PART_QUERY  = 3'd4;
    localparam logic [2:0] PART_END    = 3'd5;

    // parse phase of the front, one-hot
    typedef enum logic [5:0] {
        PH_SCHEME = 6'b000001,
        PH_SEP    = 6'b000010,
        PH_HOST   = 6'b000100,
        PH_PORT   = 6'b001000,
        PH_PATH   = 6'b010000,
        PH_QUERY  = 6'b100000
    } aus_phase_t;

    // default port to append at the end of a url
    typedef enum logic [1:0] {
        DEF_PORT_NONE = 2'd0,
        DEF_PORT_80   = 2'd1,
        DEF_PORT_443  = 2'd2
    } aus_def_port_t;

    // one classified record handed from front to back
    typedef struct packed {
        logic          has_main;   // record carries a url byte
        logic [7:0]    main_byte;
        logic [2:0]    main_part;
        logic          pct;        // main byte goes out as %XX
        logic          last;       // end record follows
        logic          status;     // 1 no match
        aus_def_port_t def_port;
        logic          def_path;
    } aus_rec_t;

endpackage

// ===== rtl/core/aus_front.sv =====
// ----------------------------------------------------------------------------
// aus_front
// matches the url pattern byte by byte and classifies each byte into a record
// ----------------------------------------------------------------------------
module aus_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      url_byte,
    input  logic            final_byte,
    output logic            push,
    output aus_pkg::aus_rec_t rec
);
    import aus_pkg::*;

    aus_phase_t phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic       secure_reg, secure_next;
    logic       host_reg, host_next;
    logic       port_reg, port_next;
    logic       path_reg, path_next;
    logic       mism_reg, mism_next;

    logic       has_main;
    logic [7:0] mbyte;
    logic [2:0] mpart;
    logic       pct;
    logic       ok;
    logic       mism_fin;

    function automatic logic [7:0] scheme_char(input logic [1:0] p);
        logic [7:0] r;
        case (p)
            2'd0:    r = 8'h68; // h
            2'd3:    r = 8'h70; // p
            default: r = 8'h74; // t
        endcase
        return r;
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F
            || c == 8'h2E || c == 8'h7E || c == 8'h26 || c == 8'h3D;
        return r;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        secure_next = secure_reg;
        host_next   = host_reg;
        port_next   = port_reg;
        path_next   = path_reg;
        mism_next   = mism_reg;
        has_main    = 1'b0;
        mbyte       = url_byte;
        mpart       = PART_SCHEME;
        pct         = 1'b0;
        if (!mism_reg)
        begin
            unique case (phase_reg)
                PH_SCHEME:
                begin
                    if (!pos_reg[2])
                    begin
                        if (url_byte == scheme_char(pos_reg[1:0]))
                        begin
                            has_main = 1'b1;
                            pos_next = pos_reg + 3'd1;
                        end
                        else
                        begin
                            mism_next = 1'b1;
                        end
                    end
                    else if (url_byte == 8'h73 && !secure_reg)
                    begin
                        secure_next = 1'b1;
                        has_main    = 1'b1;
                    end
                    else if (url_byte == 8'h3A)
                    begin
                        phase_next = PH_SEP;
                        pos_next   = 3'd1;
                    end
                    else
                    begin
                        mism_next = 1'b1;
                    end
                end
                PH_SEP:
                begin
                    if (url_byte == 8'h2F)
                    begin
                        if (pos_reg >= 3'd2)
                            phase_next = PH_HOST;
                        else
                            pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        mism_next = 1'b1;
                    end
                end
                PH_HOST:
                begin
                    if (url_byte == 8'h20)
                        mism_next = 1'b1;
                    else if (url_byte == 8'h2F || url_byte == 8'h3A)
                    begin
                        if (!host_reg)
                            mism_next = 1'b1;
                        else if (url_byte == 8'h3A)
                            phase_next = PH_PORT;
                        else
                        begin
                            path_next  = 1'b1;
                            phase_next = PH_PATH;
                            has_main   = 1'b1;
                            mpart      = PART_PATH;
                        end
                    end
                    else
                    begin
                        host_next = 1'b1;
                        has_main  = 1'b1;
                        mpart     = PART_HOST;
                    end
                end
                PH_PORT:
                begin
                    if (url_byte == 8'h20)
                        mism_next = 1'b1;
                    else if (url_byte == 8'h2F)
                    begin
                        path_next  = 1'b1;
                        phase_next = PH_PATH;
                        has_main   = 1'b1;
                        mpart      = PART_PATH;
                    end
                    else
                    begin
                        port_next = 1'b1;
                        has_main  = 1'b1;
                        mpart     = PART_PORT;
                    end
                end
                PH_PATH:
                begin
                    if (url_byte == 8'h0D || url_byte == 8'h0A)
                        mism_next = 1'b1;
                    else
                    begin
                        if (url_byte == 8'h3F)
                            phase_next = PH_QUERY;
                        has_main = 1'b1;
                        mpart    = PART_PATH;
                    end
                end
                PH_QUERY:
                begin
                    if (url_byte == 8'h0D || url_byte == 8'h0A)
                        mism_next = 1'b1;
                    else
                    begin
                        has_main = 1'b1;
                        mpart    = PART_QUERY;
                        if (url_byte == 8'h20)
                            mbyte = 8'h2B; // space goes out as plus
                        else if (!passes_plain(url_byte))
                            pct = 1'b1;
                    end
                end
                default:
                begin
                    mism_next = 1'b1;
                end
            endcase
        end

        ok = (phase_next == PH_HOST || phase_next == PH_PORT || phase_next == PH_PATH
              || phase_next == PH_QUERY) && host_next;
        mism_fin = mism_next || !ok;

        rec.has_main  = has_main;
        rec.main_byte = mbyte;
        rec.main_part = mpart;
        rec.pct       = pct;
        rec.last      = final_byte;
        rec.status    = mism_fin;
        rec.def_path  = final_byte && !mism_fin && !path_next;
        if (final_byte && !mism_fin && !port_next)
            rec.def_port = secure_next ? DEF_PORT_443 : DEF_PORT_80;
        else
            rec.def_port = DEF_PORT_NONE;
    end

    assign push = in_fire && (has_main || final_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCHEME;
            pos_reg    <= 3'd0;
            secure_reg <= 1'b0;
            host_reg   <= 1'b0;
            port_reg   <= 1'b0;
            path_reg   <= 1'b0;
            mism_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (final_byte)
            begin
                // url done, start over
                phase_reg  <= PH_SCHEME;
                pos_reg    <= 3'd0;
                secure_reg <= 1'b0;
                host_reg   <= 1'b0;
                port_reg   <= 1'b0;
                path_reg   <= 1'b0;
                mism_reg   <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                secure_reg <= secure_next;
                host_reg   <= host_next;
                port_reg   <= port_next;
                path_reg   <= path_next;
                mism_reg   <= mism_next;
            end
        end
    end

endmodule

// ===== rtl/core/aus_queue.sv =====
// ----------------------------------------------------------------------------
// aus_queue
// short record queue between the front and the back
// ----------------------------------------------------------------------------
module aus_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  aus_pkg::aus_rec_t push_rec,
    input  logic              pop,
    output aus_pkg::aus_rec_t head_rec,
    output logic              not_empty,
    output logic              full,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import aus_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aus_rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign head_rec  = slot_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign count     = cnt_reg;

endmodule

// ===== rtl/core/aus_back.sv =====
// ----------------------------------------------------------------------------
// aus_back
// expands each record into output words and holds them in an output register
// ----------------------------------------------------------------------------
module aus_back (
    input  logic              clk,
    input  logic              rst_n,
    input  aus_pkg::aus_rec_t head_rec,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic [2:0]        part,
    output logic              end_of_url,
    output logic              status
);
    import aus_pkg::*;

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [2:0] part_reg;
    logic       eou_reg;
    logic       status_reg;

    logic [3:0] len_main, len_port, len_path, total, i;
    logic [3:0] j;
    logic [7:0] it_byte;
    logic [2:0] it_part;
    logic       it_eou;
    logic       it_status;
    logic       last_item;
    logic       adv;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = 8'h30 + {4'd0, n};
        else
            r = 8'h37 + {4'd0, n};
        return r;
    endfunction

    always_comb
    begin
        len_main = head_rec.has_main ? (head_rec.pct ? 4'd3 : 4'd1) : 4'd0;
        case (head_rec.def_port)
            DEF_PORT_80:  len_port = 4'd2;
            DEF_PORT_443: len_port = 4'd3;
            default:      len_port = 4'd0;
        endcase
        len_path = {3'd0, head_rec.def_path};
        total    = len_main + len_port + len_path + {3'd0, head_rec.last};
        i        = {1'b0, idx_reg};
        j        = i - len_main;

        it_byte   = 8'h00;
        it_part   = PART_END;
        it_eou    = 1'b0;
        it_status = 1'b0;
        if (i < len_main)
        begin
            it_part = head_rec.main_part;
            if (i == 4'd0)
                it_byte = head_rec.pct ? 8'h25 : head_rec.main_byte;
            else if (i == 4'd1)
                it_byte = hex_char(head_rec.main_byte[7:4]);
            else
                it_byte = hex_char(head_rec.main_byte[3:0]);
        end
        else if (i < len_main + len_port)
        begin
            it_part = PART_PORT;
            if (head_rec.def_port == DEF_PORT_80)
                it_byte = (j == 4'd0) ? 8'h38 : 8'h30;
            else
                it_byte = (j == 4'd2) ? 8'h33 : 8'h34;
        end
        else if (i < len_main + len_port + len_path)
        begin
            it_part = PART_PATH;
            it_byte = 8'h2F;
        end
        else
        begin
            it_eou    = 1'b1;
            it_status = head_rec.status;
        end
    end

    assign last_item = (i == total - 4'd1);
    assign adv       = head_valid && (!valid_reg || !out_stall);
    assign pop       = adv && last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= last_item ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byte_reg   <= it_byte;
            part_reg   <= it_part;
            eou_reg    <= it_eou;
            status_reg <= it_status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign part       = part_reg;
    assign end_of_url = eou_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/core/absolute_url_splitter_top.sv =====
// ----------------------------------------------------------------------------
// absolute_url_splitter_top
// splits an http or https url into tagged scheme, host, port, path and query
// ----------------------------------------------------------------------------
// One url byte is taken per cycle whenever the record queue has room; the
// front decides the byte in that same cycle. The back then sends one output
// word per cycle unless out_stall holds it: one word for a plain byte, three
// for a percent-encoded query byte, and on the final byte up to three default
// port words, a default path word and the end record, so a final byte yields
// up to seven output words. in_stall rises only when the QUEUE_DEPTH record
// queue is full, which happens when the output expands faster than it drains
// or out_stall holds it.
module absolute_url_splitter_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] url_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] part,
    output logic       end_of_url,
    output logic       status
);
    import aus_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             in_fire;
    logic             q_push;
    aus_rec_t         q_push_rec;
    logic             q_pop;
    aus_rec_t         q_head;
    logic             q_not_empty;
    logic             q_full;
    logic [CNT_W-1:0] q_count;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = q_full;

    aus_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .url_byte   (url_byte),
        .final_byte (final_byte),
        .push       (q_push),
        .rec        (q_push_rec)
    );

    aus_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .pop       (q_pop),
        .head_rec  (q_head),
        .not_empty (q_not_empty),
        .full      (q_full),
        .count     (q_count)
    );

    aus_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_rec   (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .part       (part),
        .end_of_url (end_of_url),
        .status     (status)
    );

    // end record always carries the end part code
    a_end_part: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_url |-> part == PART_END)
        else $error("end record with wrong part code");

    // status is only raised on the end record
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> end_of_url)
        else $error("status set on a non-end word");

    // the back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0)
        else $error("pop from empty record queue");

    // queue fill stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("record queue overfilled");

endmodule
